// ===== rtl/ihc_pkg.sv =====
package ihc_pkg;

	// Field widths
	localparam int LUMA_W = 8;
	localparam int TIME_W = 48;
	localparam int MODE_W = 2;
	localparam int DELAY_MS_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 3;
	// 65535 ms * 1000 fits in 26 bits
	localparam int DELAY_US_W = 26;
	localparam int US_PER_MS_W = 10;

	localparam logic [US_PER_MS_W-1:0] US_PER_MS = US_PER_MS_W'(1000);

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DARK_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHT_THRESHOLD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ON_DELAY_MS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFF_DELAY_MS = 3'd4;

	// Mode codes; the fourth code holds the lamp as it is
	localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORCE_ON = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FORCE_OFF = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

	// Reset values
	localparam logic [LUMA_W-1:0] DARK_RESET = LUMA_W'(40);
	localparam logic [LUMA_W-1:0] BRIGHT_RESET = LUMA_W'(60);
	localparam logic [DELAY_US_W-1:0] ON_DELAY_US_RESET = DELAY_US_W'(3000 * 1000);
	localparam logic [DELAY_US_W-1:0] OFF_DELAY_US_RESET = DELAY_US_W'(3000 * 1000);

	// Configuration as seen by the control logic
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic mode_wr;
		logic [LUMA_W-1:0] dark;
		logic [LUMA_W-1:0] bright;
		logic [DELAY_US_W-1:0] on_us;
		logic [DELAY_US_W-1:0] off_us;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic ir_on;
		logic drive_level;
		logic switched;
		logic wait_pending;
	} res_t;

endpackage

// ===== rtl/ihc_sample_if.sv =====
interface ihc_sample_if
	import ihc_pkg::*;
	;
	logic valid;
	logic ready;
	logic [LUMA_W-1:0] luma;
	logic [TIME_W-1:0] time_us;

	modport source (output valid, output luma, output time_us, input ready);
	modport sink (input valid, input luma, input time_us, output ready);
endinterface

// ===== rtl/ihc_result_if.sv =====
interface ihc_result_if;
	logic valid;
	logic ready;
	logic ir_on;
	logic drive_level;
	logic switched;
	logic wait_pending;

	modport source (output valid, output ir_on, output drive_level, output switched,
		output wait_pending, input ready);
	modport sink (input valid, input ir_on, input drive_level, input switched,
		input wait_pending, output ready);
endinterface

// ===== rtl/ir_illuminator_hysteresis_control_top.sv =====
// Infrared illuminator control: each sample word (average luma and a 48-bit microsecond
// timestamp) yields one result word with the lamp state, its active-low drive level, a
// switched flag and a wait-pending flag. In automatic mode the lamp turns on after luma has
// stayed below the dark threshold until the on-delay deadline, and off after it has stayed
// above the bright threshold until the off-delay deadline; deadlines wrap modulo 2^48. A
// word is accepted every cycle while results are taken; its result passes the input register
// and the result register, with combinational add-and-compare logic between them. Writes to
// the configuration port take effect in the next cycle and must be made while the block is idle.
module ir_illuminator_hysteresis_control_top
	import ihc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	ihc_sample_if.sink sample,
	ihc_result_if.source result
);

	cfg_t cfg;
	res_t res_d;
	res_t res_q;
	logic valid_s1;
	logic [LUMA_W-1:0] luma_s1;
	logic [TIME_W-1:0] time_s1;
	logic out_valid_q;
	logic advance;
	logic step;

	// The input stage moves on whenever the result register is empty or being taken.
	assign advance = !out_valid_q || result.ready;
	assign step = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	ihc_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg (cfg)
	);

	ihc_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.step (step),
		.luma (luma_s1),
		.time_us (time_s1),
		.res (res_d)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			luma_s1 <= sample.luma;
			time_s1 <= sample.time_us;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.ir_on = res_q.ir_on;
	assign result.drive_level = res_q.drive_level;
	assign result.switched = res_q.switched;
	assign result.wait_pending = res_q.wait_pending;

endmodule

// ===== rtl/ihc_cfg.sv =====
module ihc_cfg
	import ihc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t cfg
);

	logic [MODE_W-1:0] mode_q;
	logic mode_wr_q;
	logic [LUMA_W-1:0] dark_q;
	logic [LUMA_W-1:0] bright_q;
	logic [DELAY_US_W-1:0] on_us_q;
	logic [DELAY_US_W-1:0] off_us_q;

	// Register writes; delays are kept in microseconds so the data path only adds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_AUTO;
			dark_q <= DARK_RESET;
			bright_q <= BRIGHT_RESET;
			on_us_q <= ON_DELAY_US_RESET;
			off_us_q <= OFF_DELAY_US_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_wdata[MODE_W-1:0];
				REG_DARK_THRESHOLD: dark_q <= cfg_wdata[LUMA_W-1:0];
				REG_BRIGHT_THRESHOLD: bright_q <= cfg_wdata[LUMA_W-1:0];
				REG_ON_DELAY_MS: on_us_q <= DELAY_US_W'(cfg_wdata[DELAY_MS_W-1:0])
					* DELAY_US_W'(US_PER_MS);
				REG_OFF_DELAY_MS: off_us_q <= DELAY_US_W'(cfg_wdata[DELAY_MS_W-1:0])
					* DELAY_US_W'(US_PER_MS);
				default: ;
			endcase
		end
	end

	// The mode strobe is registered together with the new mode value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_wr_q <= 1'b0;
		end else begin
			mode_wr_q <= cfg_we && (cfg_index == REG_MODE);
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.mode_wr = mode_wr_q;
	assign cfg.dark = dark_q;
	assign cfg.bright = bright_q;
	assign cfg.on_us = on_us_q;
	assign cfg.off_us = off_us_q;

endmodule

// ===== rtl/ihc_ctrl.sv =====
module ihc_ctrl
	import ihc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic step,
	input logic [LUMA_W-1:0] luma,
	input logic [TIME_W-1:0] time_us,
	output res_t res
);

	logic lamp_q;
	logic wait_en_q;
	logic wait_dis_q;
	logic [TIME_W-1:0] deadline_q;

	logic lamp_cur;
	logic wait_en_cur;
	logic wait_dis_cur;
	logic lamp_d;
	logic wait_en_d;
	logic wait_dis_d;
	logic [TIME_W-1:0] deadline_d;
	logic switched_d;
	logic [TIME_W-1:0] since_deadline;
	logic reached;
	logic [TIME_W-1:0] on_deadline;
	logic [TIME_W-1:0] off_deadline;

	// Wrap-aware deadline test and the two candidate deadlines.
	assign since_deadline = time_us - deadline_q;
	assign reached = !since_deadline[TIME_W-1];
	assign on_deadline = time_us + TIME_W'(cfg.on_us);
	assign off_deadline = time_us + TIME_W'(cfg.off_us);

	// A mode write still being applied is folded into the state the sample sees.
	always_comb begin
		lamp_cur = lamp_q;
		wait_en_cur = wait_en_q;
		wait_dis_cur = wait_dis_q;
		if (cfg.mode_wr) begin
			wait_en_cur = 1'b0;
			wait_dis_cur = 1'b0;
			if (cfg.mode == MODE_FORCE_ON) begin
				lamp_cur = 1'b1;
			end else if (cfg.mode == MODE_FORCE_OFF) begin
				lamp_cur = 1'b0;
			end
		end
	end

	// Hysteresis decision for one sample.
	always_comb begin
		lamp_d = lamp_cur;
		wait_en_d = wait_en_cur;
		wait_dis_d = wait_dis_cur;
		deadline_d = deadline_q;
		switched_d = 1'b0;
		if (cfg.mode == MODE_AUTO) begin
			if (!lamp_cur) begin
				if (luma < cfg.dark) begin
					if (!wait_en_cur) begin
						wait_en_d = 1'b1;
						deadline_d = on_deadline;
					end else if (reached) begin
						lamp_d = 1'b1;
						wait_en_d = 1'b0;
						switched_d = 1'b1;
					end
				end else begin
					wait_en_d = 1'b0;
				end
			end else begin
				if (luma > cfg.bright) begin
					if (!wait_dis_cur) begin
						wait_dis_d = 1'b1;
						deadline_d = off_deadline;
					end else if (reached) begin
						lamp_d = 1'b0;
						wait_dis_d = 1'b0;
						switched_d = 1'b1;
					end
				end else begin
					wait_dis_d = 1'b0;
				end
			end
		end
	end

	// Lamp state; a mode write clears the waits and applies a forced mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q <= 1'b0;
			wait_en_q <= 1'b0;
			wait_dis_q <= 1'b0;
			deadline_q <= '0;
		end else if (step) begin
			lamp_q <= lamp_d;
			wait_en_q <= wait_en_d;
			wait_dis_q <= wait_dis_d;
			deadline_q <= deadline_d;
		end else if (cfg.mode_wr) begin
			lamp_q <= lamp_cur;
			wait_en_q <= wait_en_cur;
			wait_dis_q <= wait_dis_cur;
		end
	end

	assign res.ir_on = lamp_d;
	assign res.drive_level = !lamp_d;
	assign res.switched = switched_d;
	assign res.wait_pending = wait_en_d || wait_dis_d;

`ifndef SYNTHESIS
	a_one_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!(wait_en_q && wait_dis_q))
		else $error("turn-on and turn-off waits armed together");
	a_wait_en_off: assert property (@(posedge clk) disable iff (!arst_n)
		wait_en_q |-> !lamp_q)
		else $error("turn-on wait armed while lamp is on");
	a_wait_dis_on: assert property (@(posedge clk) disable iff (!arst_n)
		wait_dis_q |-> lamp_q)
		else $error("turn-off wait armed while lamp is off");
	a_switch_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !cfg.mode_wr && res.switched) |=> (lamp_q != $past(lamp_q)))
		else $error("switched word did not toggle the lamp");
	a_mode_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.mode_wr && !step) |=> (!wait_en_q && !wait_dis_q))
		else $error("mode write left a wait armed");
`endif

endmodule
